// ===== hw/rtl/cpps_pkg.sv =====
// Shared widths, register indexes and reset values for the clock phase PI synchronizer.
`timescale 1ns / 1ps
`default_nettype none

package cpps_pkg;

  localparam int REF_W   = 63;  // reference time sample
  localparam int CT_W    = 30;  // cycle time and sync offset
  localparam int ERR_W   = 31;  // time error
  localparam int INTEG_W = 64;  // error integral
  localparam int GAIN_W  = 32;  // Q0.32 gains
  localparam int OFF_W   = 32;  // offset time result
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Multiplicand width inside the serial MAC: integral plus error needs one extra bit.
  localparam int MAC_X_W   = INTEG_W + 1;
  localparam int MAC_ACC_W = MAC_X_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 2'd3;

  localparam logic [CT_W-1:0]   CYCLE_TIME_RST  = 30'd1000000;
  localparam logic [CT_W-1:0]   SYNC_OFFSET_RST = 30'd500000;
  localparam logic [GAIN_W-1:0] P_GAIN_RST      = 32'd42949673;
  localparam logic [GAIN_W-1:0] I_GAIN_RST      = 32'd85899;

endpackage

`default_nettype wire

// ===== hw/rtl/cpps_rem_div.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cpps_rem_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cpps_pkg::REF_W-1:0]  dividend,
  input  wire logic [cpps_pkg::CT_W-1:0]   divisor,
  output logic                             done,
  output logic      [cpps_pkg::CT_W-1:0]   rem
);

  localparam int CNT_W = $clog2(cpps_pkg::REF_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(cpps_pkg::REF_W - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [cpps_pkg::REF_W-1:0]  shreg;
  logic [cpps_pkg::CT_W-1:0]   dsr;
  logic [cpps_pkg::CT_W:0]     trial;
  logic [cpps_pkg::CT_W:0]     trial_sub;

  assign trial     = {rem, shreg[cpps_pkg::REF_W-1]};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[cpps_pkg::REF_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= trial_sub[cpps_pkg::CT_W-1:0];
      end else begin
        rem <= trial[cpps_pkg::CT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpps_mac_serial.sv =====
// Bit-serial PI multiply-accumulate: one bit of both gains per cycle, then round and clamp.
`timescale 1ns / 1ps
`default_nettype none

module cpps_mac_serial (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [cpps_pkg::ERR_W-1:0]   err,
  input  wire logic signed [cpps_pkg::INTEG_W-1:0] integ,
  input  wire logic        [cpps_pkg::GAIN_W-1:0]  p_gain,
  input  wire logic        [cpps_pkg::GAIN_W-1:0]  i_gain,
  output logic                                     done,
  output logic        [cpps_pkg::OFF_W-1:0]        result
);

  localparam int XW    = cpps_pkg::MAC_X_W;
  localparam int AW    = cpps_pkg::MAC_ACC_W;
  localparam int GW    = cpps_pkg::GAIN_W;
  localparam int OW    = cpps_pkg::OFF_W;
  localparam int CNT_W = $clog2(GW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(GW - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } mac_state_t;

  mac_state_t            state;
  logic [CNT_W-1:0]      cnt;
  logic signed [XW-1:0]  x_err;
  logic signed [XW-1:0]  x_int;
  logic signed [XW-1:0]  x_sum;
  logic [GW-1:0]         gp;
  logic [GW-1:0]         gi;
  logic signed [AW-1:0]  acc;
  logic [GW-1:0]         lo;

  logic signed [XW-1:0]  addend;
  logic signed [AW:0]    step_sum;
  logic signed [AW-1:0]  quot;
  logic [OW-1:0]         sat;

  always_comb begin
    case ({gi[0], gp[0]})
      2'b01:   addend = x_err;
      2'b10:   addend = x_int;
      2'b11:   addend = x_sum;
      default: addend = '0;
    endcase
  end

  assign step_sum = {acc[AW-1], acc} + {{2{addend[XW-1]}}, addend};

  // acc holds floor(sum / 2^32); step up by one for truncation toward zero
  assign quot = acc + {{(AW-1){1'b0}}, (acc[AW-1] && (lo != '0))};

  always_comb begin
    if (!quot[AW-1] && (quot[AW-2:OW-1] != '0)) begin
      sat = {1'b0, {(OW-1){1'b1}}};
    end else if (quot[AW-1] && (quot[AW-2:OW-1] != '1)) begin
      sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat = quot[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: if (start) state <= ST_PREP;
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) state <= ST_FIN;
        end
        ST_FIN: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      x_err <= XW'(err);
      x_int <= XW'(integ);
      gp    <= p_gain;
      gi    <= i_gain;
      acc   <= '0;
      lo    <= '0;
    end
    if (state == ST_PREP) begin
      x_sum <= x_int + x_err;
    end
    if (state == ST_RUN) begin
      acc <= step_sum[AW:1];
      lo  <= {step_sum[0], lo[GW-1:1]};
      gp  <= gp >> 1;
      gi  <= gi >> 1;
    end
    if (state == ST_FIN) begin
      result <= sat;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/clock_phase_pi_sync.sv =====
// Top level of the clock phase PI synchronizer.
//
// One reference time sample comes in on the s_ stream, one result leaves on
// the m_ stream for each sample: the PI correction for the next bus period and
// the wrapped time error. The user must write registers via cfg_we / cfg_index /
// cfg_data only while no sample is in flight; the block does not enforce it.
//
// The remainder is taken bit-serially, one bit of the 63-bit phase difference
// per cycle; then the serial PI multiply takes one bit of both 32-bit gains
// per cycle plus setup and clamp, with control states between. One sample is
// worked at a time, so a new sample is accepted only once the last one has
// left the output step; s_tready is high whenever the block is idle, even
// while a finished result still waits on m_tready.
// If the receiver stalls, the result holds in the output register and a
// second result waits in the last step until that register frees up.
// Reset restores the register defaults and clears the error integral.
`timescale 1ns / 1ps
`default_nettype none

module clock_phase_pi_sync (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [63:0]                         s_tdata,  // [62:0] reference_time
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [63:0]                              m_tdata,  // [31:0] offset_time, [62:32] time_error
  input  wire logic                                cfg_we,
  input  wire logic [cpps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cpps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RW = cpps_pkg::REF_W;
  localparam int CW = cpps_pkg::CT_W;
  localparam int EW = cpps_pkg::ERR_W;
  localparam int IW = cpps_pkg::INTEG_W;
  localparam int OW = cpps_pkg::OFF_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIFF  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_ERR   = 7'b0001000,
    ST_INTEG = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } sync_state_t;

  sync_state_t              state;
  logic [CW-1:0]            cycle_time;
  logic [CW-1:0]            sync_offset;
  logic [cpps_pkg::GAIN_W-1:0] p_gain;
  logic [cpps_pkg::GAIN_W-1:0] i_gain;
  logic [RW-1:0]            ref_time;
  logic                     diff_neg;
  logic signed [EW-1:0]     err;
  logic signed [IW-1:0]     integ;

  logic [RW:0]              diff;
  logic [RW-1:0]            diff_mag;
  logic                     div_done;
  logic [CW-1:0]            rem;
  logic [CW+1:0]            err_next;
  logic signed [IW:0]       integ_sum;
  logic signed [IW-1:0]     integ_next;
  logic                     mac_done;
  logic [OW-1:0]            mac_result;
  logic                     out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_time  <= cpps_pkg::CYCLE_TIME_RST;
      sync_offset <= cpps_pkg::SYNC_OFFSET_RST;
      p_gain      <= cpps_pkg::P_GAIN_RST;
      i_gain      <= cpps_pkg::I_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpps_pkg::REG_CYCLE_TIME:  cycle_time  <= cfg_data[CW-1:0];
        cpps_pkg::REG_SYNC_OFFSET: sync_offset <= cfg_data[CW-1:0];
        cpps_pkg::REG_P_GAIN:      p_gain      <= cfg_data;
        cpps_pkg::REG_I_GAIN:      i_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  // signed phase difference, split into sign and magnitude
  assign diff     = {1'b0, ref_time} - {{(RW+1-CW){1'b0}}, sync_offset};
  assign diff_mag = diff[RW] ? RW'(~diff + 1'b1) : diff[RW-1:0];

  cpps_rem_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIFF),
    .dividend (diff_mag),
    .divisor  (cycle_time),
    .done     (div_done),
    .rem      (rem)
  );

  // time error: negated wrapped remainder if the difference is positive, plain remainder if negative
  always_comb begin
    if (cycle_time == '0) begin
      err_next = '0;
    end else if (diff_neg) begin
      err_next = {2'b00, rem};
    end else if (rem > (cycle_time >> 1)) begin
      err_next = {2'b00, cycle_time} - {2'b00, rem};
    end else begin
      err_next = '0 - {2'b00, rem};
    end
  end

  // saturating integral update
  assign integ_sum = {integ[IW-1], integ} + {{(IW+1-EW){err[EW-1]}}, err};
  always_comb begin
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      integ_next = integ_sum[IW-1:0];
    end
  end

  cpps_mac_serial u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_INTEG),
    .err    (err),
    .integ  (integ_next),
    .p_gain (p_gain),
    .i_gain (i_gain),
    .done   (mac_done),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      integ    <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:  if (s_tvalid) state <= ST_DIFF;
        ST_DIFF:  state <= ST_DIV;
        ST_DIV:   if (div_done) state <= ST_ERR;
        ST_ERR:   state <= ST_INTEG;
        ST_INTEG: begin
          integ <= integ_next;
          state <= ST_MUL;
        end
        ST_MUL:   if (mac_done) state <= ST_OUT;
        ST_OUT:   if (out_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) ref_time <= s_tdata[RW-1:0];
    if (state == ST_DIFF) diff_neg <= diff[RW];
    if (state == ST_ERR) err <= err_next[EW-1:0];
    if (state == ST_OUT && out_free) m_tdata <= {1'b0, err, mac_result};
  end

endmodule

`default_nettype wire

// ===== dv/tb_clock_phase_pi_sync.sv =====
// Self-checking testbench for the clock phase PI synchronizer: directed table, then random phases.
`timescale 1ns / 1ps

module tb_clock_phase_pi_sync;
  import cpps_pkg::*;

  localparam int ITEMS_RANDOM = 500;
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIR_LEN      = 29;

  typedef struct packed {
    logic [OFF_W-1:0] offset_time;
    logic [ERR_W-1:0] time_error;
  } pi_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // value: register data for ROW_CFG, reference time for ROW_SAMPLE (idx unused there)
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [63:0]           value;
    logic                  typed;
    pi_result_t            res;
  } stim_row_t;

  localparam pi_result_t NO_RES = '0;

  localparam stim_row_t DIR_ROWS [DIR_LEN] = '{
    // reset settings: cycle 1 ms, offset 0.5 ms
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd500000,             1'b1, '{32'd0, 31'd0}},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd0,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd1000000,            1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd1000001,            1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd1499999,            1'b0, NO_RES},
    // zero cycle time with zero gains: no error, no correction
    '{ROW_CFG,    REG_P_GAIN,      64'd0,                  1'b0, NO_RES},
    '{ROW_CFG,    REG_I_GAIN,      64'd0,                  1'b0, NO_RES},
    '{ROW_CFG,    REG_CYCLE_TIME,  64'd0,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{32'd0, 31'd0}},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd12345,              1'b1, '{32'd0, 31'd0}},
    // cycle time below the usable minimum
    '{ROW_CFG,    REG_CYCLE_TIME,  64'd1,                  1'b0, NO_RES},
    '{ROW_CFG,    REG_SYNC_OFFSET, 64'd0,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd987654321,          1'b1, '{32'd0, 31'd0}},
    '{ROW_CFG,    REG_CYCLE_TIME,  64'd3,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd5,                  1'b0, NO_RES},
    // all-ones writes (cycle time masks to 2^30-1), full gains, drive to negative clamp
    '{ROW_CFG,    REG_CYCLE_TIME,  64'hFFFF_FFFF,          1'b0, NO_RES},
    '{ROW_CFG,    REG_P_GAIN,      64'hFFFF_FFFF,          1'b0, NO_RES},
    '{ROW_CFG,    REG_I_GAIN,      64'hFFFF_FFFF,          1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd536870911,          1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd536870911,          1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd536870911,          1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd536870911,          1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd536870911,          1'b1,
      '{32'h8000_0000, -31'sd536870911}},
    // large positive error, drive to positive clamp
    '{ROW_CFG,    REG_SYNC_OFFSET, 64'd1000000000,         1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd0,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd0,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd0,                  1'b0, NO_RES},
    '{ROW_SAMPLE, REG_CYCLE_TIME,  64'd0,                  1'b1,
      '{32'h7FFF_FFFF, 31'd1000000000}}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata   = '0;   // [62:0] reference_time
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [63:0]           m_tdata;          // [31:0] offset_time, [62:32] time_error
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor copy of the registers and the integral
  logic [CT_W-1:0]   cyc_ns;
  logic [CT_W-1:0]   sync_ns;
  logic [GAIN_W-1:0] kp;
  logic [GAIN_W-1:0] ki;
  longint            integral;

  pi_result_t pending_corrections [$];
  pi_result_t want_res;
  bit         quiet = 1'b0;   // no idling on either side
  int         rx_hold = 0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         samples_sent = 0;
  int         cycle_count = 0;

  always #5 clk = ~clk;

  clock_phase_pi_sync u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic pi_result_t predict_correction(logic [REF_W-1:0] stamp);
    logic [63:0]         rem;
    longint              err;
    logic signed [64:0]  sum65;
    logic signed [127:0] e_w, i_w, kp_w, ki_w, acc, mag;
    logic [127:0]        q;
    pi_result_t          r;
    err = 0;
    if (cyc_ns != 0) begin
      if (stamp >= sync_ns) begin
        rem = (64'(stamp) - 64'(sync_ns)) % 64'(cyc_ns);
        // above half a cycle the phase wraps to the next period
        err = (rem > 64'(cyc_ns >> 1)) ? longint'(64'(cyc_ns) - rem) : -longint'(rem);
      end else begin
        rem = (64'(sync_ns) - 64'(stamp)) % 64'(cyc_ns);
        err = longint'(rem);
      end
    end
    sum65 = integral + err;
    if (sum65[64] != sum65[63])
      integral = sum65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    else
      integral = sum65[63:0];
    e_w  = err;
    i_w  = integral;
    kp_w = {96'd0, kp};
    ki_w = {96'd0, ki};
    acc  = e_w * kp_w + i_w * ki_w;
    // shift the magnitude so the quotient truncates toward zero
    mag  = acc[127] ? -acc : acc;
    q    = mag >> 32;
    if (acc[127])
      r.offset_time = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    else
      r.offset_time = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    r.time_error = err[ERR_W-1:0];
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 32'h0400_0000);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s on result %0d: got 0x%0h, expected 0x%0h",
               what, results_seen, got, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_CYCLE_TIME:  cyc_ns  = data[CT_W-1:0];
      REG_SYNC_OFFSET: sync_ns = data[CT_W-1:0];
      REG_P_GAIN:      kp      = data;
      REG_I_GAIN:      ki      = data;
      default: ;
    endcase
  endtask

  // drop valid, then wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
  endtask

  // valid stays high after the transaction; the next call lowers or reuses it
  task automatic send_sample(logic [REF_W-1:0] stamp, logic typed, pi_result_t typed_res);
    pi_result_t r;
    int         gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, stamp};
    do @(posedge clk); while (!s_tready);
    r = predict_correction(stamp);
    pending_corrections.push_back(typed ? typed_res : r);
    samples_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_corrections.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want_res = pending_corrections.pop_front();
        if (m_tdata[31:0] !== want_res.offset_time)
          report_mismatch("offset_time", m_tdata[31:0], want_res.offset_time);
        if (m_tdata[62:32] !== want_res.time_error)
          report_mismatch("time_error", m_tdata[62:32], want_res.time_error);
      end
      rx_hold = quiet ? 0 : $urandom_range(0, 4);
    end
  end

  // receiver: hold off a drawn number of cycles while a result is offered
  always @(negedge clk) begin
    if (m_tvalid && rx_hold != 0) begin
      m_tready = 1'b0;
      rx_hold  = rx_hold - 1;
    end else if (!m_tvalid && !quiet) begin
      m_tready = 1'($urandom_range(0, 1));
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_corrections.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int          directed;
    logic [31:0] ct_v, so_v;
    logic [63:0] tmp;
    logic [63:0] last_stamp;
    longint      jitter;

    cyc_ns   = CYCLE_TIME_RST;
    sync_ns  = SYNC_OFFSET_RST;
    kp       = P_GAIN_RST;
    ki       = I_GAIN_RST;
    integral = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value[CFG_DATA_W-1:0]);
      end else begin
        send_sample(DIR_ROWS[i].value[REF_W-1:0], DIR_ROWS[i].typed, DIR_ROWS[i].res);
      end
    end
    directed = samples_sent;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        ct_v = '1;
        so_v = '1;
      end else if (ph == PHASES - 1) begin
        ct_v = CYCLE_TIME_RST;
        so_v = SYNC_OFFSET_RST;
      end else begin
        case ($urandom_range(0, 4))
          0: ct_v = $urandom_range(1, 16);
          1: ct_v = 1000;
          2: ct_v = $urandom_range(1000, 100000);
          3: ct_v = $urandom_range(1000, 1000000000);
          default: ct_v = $urandom();
        endcase
        so_v = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000000000);
      end
      wait_idle();
      quiet = (ph == 2);
      write_reg(REG_CYCLE_TIME, ct_v);
      write_reg(REG_SYNC_OFFSET, so_v);
      write_reg(REG_P_GAIN, (ph == 0) ? '1 : (ph == PHASES - 1) ? P_GAIN_RST : pick_gain());
      write_reg(REG_I_GAIN, (ph == 0) ? '1 : (ph == PHASES - 1) ? I_GAIN_RST : pick_gain());
      last_stamp = 64'(sync_ns) + 64'($urandom()) * cyc_ns;

      repeat (ITEMS_RANDOM / PHASES) begin
        case ($urandom_range(0, 9))
          0, 1: tmp = {$urandom(), $urandom()};
          // just around the half-cycle wrap point
          2, 3: tmp = 64'($urandom()) * cyc_ns + sync_ns + (cyc_ns >> 1)
                      + $urandom_range(0, 2) - 1;
          4: tmp = $urandom_range(0, sync_ns);
          default: begin
            // one sample per bus cycle with a little jitter
            jitter = longint'($urandom_range(0, 2000)) - 1000;
            tmp = last_stamp + cyc_ns + jitter;
          end
        endcase
        last_stamp = tmp;
        send_sample(tmp[REF_W-1:0], 1'b0, NO_RES);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples (%0d directed, %0d random over %0d register settings)",
             samples_sent, directed, samples_sent - directed, PHASES);
    $display("Checked %0d results in %0d cycles, %0d mismatches",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cpps_pkg.sv
hw/rtl/cpps_rem_div.sv
hw/rtl/cpps_mac_serial.sv
hw/rtl/clock_phase_pi_sync.sv
dv/tb_clock_phase_pi_sync.sv
